// File: src/rtst_pkg.sv
package rtst_pkg;

	// Default table depth and the number of priority levels.
	localparam int TASKS_DEF   = 32;
	localparam int PRIO_LEVELS = 32;

	// Stream widths.
	localparam int IN_DATA_W  = 16;
	localparam int IN_USER_W  = 3;
	localparam int OUT_DATA_W = 24;

	// Field widths.
	localparam int MODE_W  = 2;
	localparam int TASK_W  = 5;
	localparam int PRIO_W  = 5;
	localparam int STATE_W = 4;
	localparam int CNT_W   = 8;
	localparam int STAT_W  = 2;
	localparam int ACT_W   = 2;

	// Extended target width, wide enough to compare against any table depth up to 511.
	localparam int TGT_W = 9;

	// Request codes.
	localparam logic [MODE_W-1:0] MODE_CREATE  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SUSPEND = 2'd1;
	localparam logic [MODE_W-1:0] MODE_RESUME  = 2'd2;
	localparam logic [MODE_W-1:0] MODE_DELETE  = 2'd3;

	// Task state codes.
	localparam logic [STATE_W-1:0] ST_RDY     = 4'd0;
	localparam logic [STATE_W-1:0] ST_PEND_TO = 4'd3;
	localparam logic [STATE_W-1:0] ST_SUSP    = 4'd4;
	localparam logic [STATE_W-1:0] ST_DEL     = 4'd8;

	// Status codes.
	localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STAT_W-1:0] STAT_INVALID  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_NOT_SUSP = 2'd2;
	localparam logic [STAT_W-1:0] STAT_IDLE_DEL = 2'd3;

	// List action codes.
	localparam logic [ACT_W-1:0] ACT_NONE     = 2'd0;
	localparam logic [ACT_W-1:0] ACT_INS_RDY  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_RMV_RDY  = 2'd2;
	localparam logic [ACT_W-1:0] ACT_RMV_TICK = 2'd3;

	// Suspend counter limits.
	localparam logic [CNT_W-1:0] CNT_ONE = 8'd1;
	localparam logic [CNT_W-1:0] CNT_MAX = 8'd255;

	// Reset value of the idle task register.
	localparam logic [TASK_W-1:0] IDLE_RST = 5'd31;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;   // capture a request and read its task entry
		logic exec;   // update the entry and load the result register
	} dp_cmd_t;

endpackage

// File: src/rtst_ctrl.sv
module rtst_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	output logic             m_tvalid,
	input  logic             m_tready,
	output rtst_pkg::dp_cmd_t cmd
);
	import rtst_pkg::*;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_EXEC = 1'b1;

	logic state_q;
	logic out_valid_q;
	logic out_free;

	// The result register is free when empty or being taken this cycle.
	assign out_free  = !out_valid_q || m_tready;
	assign s_tready  = (state_q == S_IDLE);
	assign cmd.load  = s_tvalid && s_tready;
	assign cmd.exec  = (state_q == S_EXEC) && out_free;
	assign m_tvalid  = out_valid_q;

	// Sequencer: capture and read, then update once the result slot is free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.load) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (cmd.exec) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.exec) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

// File: src/rtst_dpath.sv
module rtst_dpath #(
	parameter int TASKS = rtst_pkg::TASKS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  rtst_pkg::dp_cmd_t              cmd,
	input  logic                           cfg_wr_en,
	input  logic [rtst_pkg::TASK_W-1:0]    cfg_wr_data,
	input  logic [rtst_pkg::IN_DATA_W-1:0] s_tdata,
	input  logic [rtst_pkg::IN_USER_W-1:0] s_tuser,
	output logic [rtst_pkg::OUT_DATA_W-1:0] m_tdata
);
	import rtst_pkg::*;

	localparam int IDX_W = (TASKS > 1) ? $clog2(TASKS) : 1;
	localparam logic [TGT_W-1:0] TASKS_LIM = TGT_W'(TASKS);
	localparam logic [TGT_W-1:0] PRIO_LIM  = TGT_W'(PRIO_LEVELS);
	localparam logic [TGT_W-1:0] PRIO_TOP  = TGT_W'(PRIO_LEVELS - 1);

	// Entry storage.
	logic [STATE_W-1:0] state_mem [TASKS];
	logic [CNT_W-1:0]   cnt_mem   [TASKS];
	logic [PRIO_W-1:0]  prio_mem  [TASKS];
	logic [TASKS-1:0]   valid_q;

	logic [TASK_W-1:0]  idle_q;
	logic [MODE_W-1:0]  mode_q;
	logic [TGT_W-1:0]   tgt_q;
	logic [PRIO_W-1:0]  preq_q;
	logic [STATE_W-1:0] st_rd_q;
	logic [CNT_W-1:0]   cnt_rd_q;
	logic [PRIO_W-1:0]  prio_rd_q;
	logic               vld_rd_q;

	// Request fields.
	logic [MODE_W-1:0]  in_mode;
	logic               in_use_cur;
	logic [TASK_W-1:0]  in_task;
	logic [TASK_W-1:0]  in_cur;
	logic [PRIO_W-1:0]  in_prio;
	logic [TASK_W-1:0]  in_tgt;
	logic [TGT_W-1:0]   in_tgt_x;
	logic [IDX_W-1:0]   rd_idx;
	logic [IDX_W-1:0]   wr_idx;

	// Update results.
	logic               oor;
	logic [STATE_W-1:0] st;
	logic [CNT_W-1:0]   cnt;
	logic [STATE_W-1:0] nstate;
	logic [CNT_W-1:0]   ncnt;
	logic [STAT_W-1:0]  status;
	logic [ACT_W-1:0]   action;
	logic               resched;
	logic [PRIO_W-1:0]  prio_clamp;
	logic               prio_we;
	logic [PRIO_W-1:0]  list_prio;
	logic [TASK_W-1:0]  list_task;
	logic               entry_we;

	assign in_task    = s_tdata[4:0];
	assign in_cur     = s_tdata[9:5];
	assign in_prio    = s_tdata[14:10];
	assign in_mode    = s_tuser[1:0];
	assign in_use_cur = s_tuser[2];

	// Only suspend and delete may target the running task.
	assign in_tgt   = (in_use_cur && (in_mode == MODE_SUSPEND || in_mode == MODE_DELETE))
		? in_cur : in_task;
	assign in_tgt_x = TGT_W'(in_tgt);
	assign rd_idx   = in_tgt_x[IDX_W-1:0];
	assign wr_idx   = tgt_q[IDX_W-1:0];

	// Idle task register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_q <= IDLE_RST;
		end else if (cfg_wr_en) begin
			idle_q <= cfg_wr_data;
		end
	end

	// Capture the request and read its entry.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q    <= in_mode;
			tgt_q     <= in_tgt_x;
			preq_q    <= in_prio;
			st_rd_q   <= state_mem[rd_idx];
			cnt_rd_q  <= cnt_mem[rd_idx];
			prio_rd_q <= prio_mem[rd_idx];
			vld_rd_q  <= valid_q[rd_idx];
		end
	end

	// Entry update.
	always_comb begin
		oor        = (tgt_q >= TASKS_LIM);
		st         = vld_rd_q ? st_rd_q : ST_DEL;
		cnt        = vld_rd_q ? cnt_rd_q : '0;
		prio_clamp = ({4'd0, preq_q} >= PRIO_LIM) ? PRIO_TOP[PRIO_W-1:0] : preq_q;
		nstate     = oor ? ST_DEL : st;
		ncnt       = cnt;
		status     = STAT_OK;
		action     = ACT_NONE;
		resched    = 1'b0;
		prio_we    = 1'b0;
		list_prio  = prio_rd_q;
		if (oor) begin
			status = STAT_INVALID;
		end else begin
			unique case (mode_q)
				MODE_CREATE: begin
					nstate    = ST_RDY;
					ncnt      = '0;
					action    = ACT_INS_RDY;
					prio_we   = 1'b1;
					list_prio = prio_clamp;
				end
				MODE_SUSPEND: begin
					if (st <= ST_PEND_TO) begin
						nstate  = st + ST_SUSP;
						ncnt    = CNT_ONE;
						action  = (st == ST_RDY) ? ACT_RMV_RDY : ACT_NONE;
						resched = 1'b1;
					end else if (st < ST_DEL) begin
						if (cnt < CNT_MAX) begin
							ncnt = cnt + CNT_ONE;
						end
						resched = 1'b1;
					end else begin
						status = STAT_INVALID;
					end
				end
				MODE_RESUME: begin
					if (st <= ST_PEND_TO) begin
						status  = STAT_NOT_SUSP;
						resched = 1'b1;
					end else if (st < ST_DEL) begin
						if (cnt <= CNT_ONE) begin
							ncnt   = '0;
							nstate = st - ST_SUSP;
							action = (st == ST_SUSP) ? ACT_INS_RDY : ACT_NONE;
						end else begin
							ncnt = cnt - CNT_ONE;
						end
						resched = 1'b1;
					end else begin
						status = STAT_INVALID;
					end
				end
				MODE_DELETE: begin
					if (tgt_q == TGT_W'(idle_q)) begin
						status = STAT_IDLE_DEL;
					end else if (st < ST_DEL) begin
						if (st == ST_RDY) begin
							action = ACT_RMV_RDY;
						end else if (st != ST_SUSP) begin
							action = ACT_RMV_TICK;
						end
						nstate  = ST_DEL;
						ncnt    = '0;
						resched = 1'b1;
					end else begin
						status = STAT_INVALID;
					end
				end
				default: begin
					status = STAT_INVALID;
				end
			endcase
		end
		list_task = (action != ACT_NONE) ? tgt_q[TASK_W-1:0] : '0;
		if (action == ACT_NONE) begin
			list_prio = '0;
		end
	end

	// A refused request within the table writes back the unchanged entry, which is harmless.
	assign entry_we = cmd.exec && !oor;

	// Entry write-back.
	always_ff @(posedge clk) begin
		if (entry_we) begin
			state_mem[wr_idx] <= nstate;
			cnt_mem[wr_idx]   <= ncnt;
		end
		if (entry_we && prio_we) begin
			prio_mem[wr_idx] <= prio_clamp;
		end
	end

	// Entry valid bits; an entry not yet written reads as deleted.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (entry_we) begin
			valid_q[wr_idx] <= 1'b1;
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			m_tdata <= {5'd0, resched, nstate, list_prio, list_task, action, status};
		end
	end

endmodule

// File: src/rtos_task_state_table_unit.sv
// Task state table for an RTOS scheduler helper. Each request (create, suspend,
// resume or delete) names a task entry, or the running task for suspend and
// delete, and returns one result item with a status, the ready-list or
// tick-list action for the scheduler, the task's new state and a reschedule
// flag. Each item is captured and its task entry read from the state, counter
// and priority memories, then the entry is updated and the result register
// loaded; the update waits while an earlier result is still held. The table
// comes out of reset with every task deleted, by way of per-entry valid bits,
// so no clearing pass is needed. The user must write the idle task index
// through the configuration port while the block is idle; nothing enforces it.
module rtos_task_state_table_unit #(
	parameter int TASKS = rtst_pkg::TASKS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [rtst_pkg::TASK_W-1:0]     cfg_wr_data,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// task_req[4:0], current_task[9:5], priority_req[14:10], zero fill
	input  logic [rtst_pkg::IN_DATA_W-1:0]  s_tdata,
	// mode[1:0], use_current[2]
	input  logic [rtst_pkg::IN_USER_W-1:0]  s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// status[1:0], list_action[3:2], list_task[8:4], list_priority[13:9],
	// new_state[17:14], reschedule[18], zero fill
	output logic [rtst_pkg::OUT_DATA_W-1:0] m_tdata
);
	import rtst_pkg::*;

	dp_cmd_t cmd;

	// Sequencer.
	rtst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	// Task table and update logic.
	rtst_dpath #(
		.TASKS (TASKS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tdata     (m_tdata)
	);

endmodule

// File: dv/tb_rtos_task_state_table_unit.sv
`timescale 1ns / 100ps

module tb_rtos_task_state_table_unit;
	import rtst_pkg::*;

	// One request item as it travels on the input stream.
	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [TASK_W-1:0] task_req;
		logic              use_current;
		logic [TASK_W-1:0] current_task;
		logic [PRIO_W-1:0] priority_req;
	} request_t;

	// One result item, laid out as on m_tdata from the top bit down.
	typedef struct packed {
		logic               reschedule;
		logic [STATE_W-1:0] new_state;
		logic [PRIO_W-1:0]  list_priority;
		logic [TASK_W-1:0]  list_task;
		logic [ACT_W-1:0]   list_action;
		logic [STAT_W-1:0]  status;
	} result_t;

	// A known answer travels beside each request until the block accepts it.
	typedef struct {
		bit      typed;
		result_t res;
	} answer_t;

	typedef struct {
		request_t req;
		bit       typed;
		result_t  res;
	} row_t;

	localparam int RES_W = $bits(result_t);
	localparam int DIRECTED_ROWS = 24;
	localparam int PHASES = 5;
	localparam int PHASE_ITEMS = 290;
	localparam int LONG_HOLD = 60;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [TASK_W-1:0]     cfg_wr_data = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [IN_USER_W-1:0]  s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;

	// Shadow copy of the task table and the idle task register.
	logic [STATE_W-1:0] entry_state [TASKS_DEF];
	logic [CNT_W-1:0]   entry_count [TASKS_DEF];
	logic [PRIO_W-1:0]  entry_prio  [TASKS_DEF];
	logic [TASK_W-1:0]  idle_task_sel = IDLE_RST;

	result_t pending_results [$];
	answer_t known_answers [$];
	int      fail_count = 0;
	bit      quiet = 1'b0;
	bit      long_hold_req = 1'b0;

	request_t accepted_req;
	result_t  table_res;
	result_t  want;
	result_t  got;
	answer_t  note;

	rtos_task_state_table_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata)
	);

	always #2 clk = ~clk;

	// Applies one request to the shadow table and returns the answer it earns.
	function automatic result_t apply_request(input request_t r);
		logic [TASK_W-1:0]  tgt;
		logic [STATE_W-1:0] st;
		result_t            res;
		res = '0;
		if ((r.mode == MODE_SUSPEND || r.mode == MODE_DELETE) && r.use_current)
			tgt = r.current_task;
		else
			tgt = r.task_req;
		st = entry_state[tgt];
		res.new_state = st;
		case (r.mode)
			MODE_CREATE: begin
				entry_prio[tgt] = r.priority_req;
				entry_state[tgt] = ST_RDY;
				entry_count[tgt] = '0;
				res.new_state = ST_RDY;
				res.list_action = ACT_INS_RDY;
			end
			MODE_SUSPEND: begin
				if (st <= ST_PEND_TO) begin
					res.new_state = st + ST_SUSP;
					entry_count[tgt] = CNT_ONE;
					if (st == ST_RDY)
						res.list_action = ACT_RMV_RDY;
					res.reschedule = 1'b1;
				end else if (st < ST_DEL) begin
					if (entry_count[tgt] < CNT_MAX)
						entry_count[tgt] = entry_count[tgt] + CNT_ONE;
					res.reschedule = 1'b1;
				end else begin
					res.status = STAT_INVALID;
				end
				entry_state[tgt] = res.new_state;
			end
			MODE_RESUME: begin
				if (st <= ST_PEND_TO) begin
					res.status = STAT_NOT_SUSP;
					res.reschedule = 1'b1;
				end else if (st < ST_DEL) begin
					// The base state returns once the nesting count runs out.
					if (entry_count[tgt] <= CNT_ONE) begin
						entry_count[tgt] = '0;
						res.new_state = st - ST_SUSP;
						if (res.new_state == ST_RDY)
							res.list_action = ACT_INS_RDY;
					end else begin
						entry_count[tgt] = entry_count[tgt] - CNT_ONE;
					end
					res.reschedule = 1'b1;
				end else begin
					res.status = STAT_INVALID;
				end
				entry_state[tgt] = res.new_state;
			end
			default: begin
				if (tgt == idle_task_sel) begin
					res.status = STAT_IDLE_DEL;
				end else if (st < ST_DEL) begin
					if (st == ST_RDY)
						res.list_action = ACT_RMV_RDY;
					else if (st != ST_SUSP)
						res.list_action = ACT_RMV_TICK;
					entry_state[tgt] = ST_DEL;
					entry_count[tgt] = '0;
					res.new_state = ST_DEL;
					res.reschedule = 1'b1;
				end else begin
					res.status = STAT_INVALID;
				end
			end
		endcase
		if (res.list_action != ACT_NONE) begin
			res.list_task = tgt;
			res.list_priority = entry_prio[tgt];
		end
		return res;
	endfunction

	function automatic result_t outcome(input logic [STAT_W-1:0] status,
			input logic [ACT_W-1:0] action, input logic [TASK_W-1:0] tsk,
			input logic [PRIO_W-1:0] prio, input logic [STATE_W-1:0] state,
			input logic resched);
		result_t res;
		res.status = status;
		res.list_action = action;
		res.list_task = tsk;
		res.list_priority = prio;
		res.new_state = state;
		res.reschedule = resched;
		return res;
	endfunction

	// Most targets come from a few tasks so that entries see long histories.
	function automatic logic [TASK_W-1:0] pick_task();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 6)
			return TASK_W'($urandom_range(0, 7));
		else if (pick < 8)
			return idle_task_sel;
		else
			return TASK_W'($urandom_range(0, 31));
	endfunction

	function automatic request_t random_request();
		request_t r;
		int       pick;
		pick = $urandom_range(0, 9);
		if (pick < 2)
			r.mode = MODE_CREATE;
		else if (pick < 5)
			r.mode = MODE_SUSPEND;
		else if (pick < 8)
			r.mode = MODE_RESUME;
		else
			r.mode = MODE_DELETE;
		r.task_req = pick_task();
		r.use_current = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 1) == 0)
			r.current_task = pick_task();
		else
			r.current_task = TASK_W'($urandom_range(0, 31));
		r.priority_req = PRIO_W'($urandom_range(0, 31));
		return r;
	endfunction

	task automatic report_field(input string name, input logic [7:0] exp_val,
			input logic [7:0] act_val);
		$display("%0t ns: %s mismatch, expected %0d, actual %0d",
			$time, name, exp_val, act_val);
		fail_count++;
	endtask

	// Offers one item, at times after a random gap, unless the run is in its quiet part.
	task automatic send_item(input request_t r, input bit typed, input result_t res);
		answer_t a;
		a.typed = typed;
		a.res = res;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		known_answers.push_back(a);
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, r.priority_req, r.current_task, r.task_req};
		s_tuser <= {r.use_current, r.mode};
		do @(posedge clk); while (s_tready !== 1'b1);
	endtask

	// Stops offering and waits until every result has come out.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0 || known_answers.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_idle_task(input logic [TASK_W-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		idle_task_sel = value;
	endtask

	// Predicts on every accepted item and checks every delivered one.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				accepted_req.mode = s_tuser[1:0];
				accepted_req.use_current = s_tuser[2];
				accepted_req.task_req = s_tdata[4:0];
				accepted_req.current_task = s_tdata[9:5];
				accepted_req.priority_req = s_tdata[14:10];
				table_res = apply_request(accepted_req);
				note = known_answers.pop_front();
				pending_results.push_back(note.typed ? note.res : table_res);
			end
			if (m_tvalid && m_tready) begin
				got = m_tdata[RES_W-1:0];
				if (pending_results.size() == 0) begin
					$display("%0t ns: result item with none expected, expected none, actual %h",
						$time, m_tdata);
					fail_count++;
				end else begin
					want = pending_results.pop_front();
					if (got.status !== want.status)
						report_field("status", 8'(want.status), 8'(got.status));
					if (got.list_action !== want.list_action)
						report_field("list_action", 8'(want.list_action),
							8'(got.list_action));
					if (got.list_task !== want.list_task)
						report_field("list_task", 8'(want.list_task), 8'(got.list_task));
					if (got.list_priority !== want.list_priority)
						report_field("list_priority", 8'(want.list_priority),
							8'(got.list_priority));
					if (got.new_state !== want.new_state)
						report_field("new_state", 8'(want.new_state), 8'(got.new_state));
					if (got.reschedule !== want.reschedule)
						report_field("reschedule", 8'(want.reschedule),
							8'(got.reschedule));
					if (m_tdata[OUT_DATA_W-1:RES_W] !== '0)
						report_field("zero fill", 8'd0, 8'(m_tdata[OUT_DATA_W-1:RES_W]));
				end
			end
		end
	end

	// Result side: short random stalls, and one long hold-off on request.
	initial begin
		int stall;
		stall = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				stall = LONG_HOLD;
			end else if (stall == 0 && !quiet && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(1, 5);
			end
			if (stall > 0) begin
				stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Stimulus: directed table, then random phases under several idle tasks.
	initial begin
		row_t              directed [DIRECTED_ROWS];
		request_t          r;
		logic [TASK_W-1:0] sat_task;
		for (int i = 0; i < TASKS_DEF; i++) begin
			entry_state[i] = ST_DEL;
			entry_count[i] = '0;
			entry_prio[i] = '0;
		end
		directed = '{
			// Requests on deleted entries straight after reset.
			'{'{MODE_SUSPEND, 5'd0, 1'b0, 5'd0, 5'd0}, 1'b1,
				outcome(STAT_INVALID, ACT_NONE, 5'd0, 5'd0, ST_DEL, 1'b0)},
			'{'{MODE_RESUME, 5'd7, 1'b0, 5'd0, 5'd0}, 1'b1,
				outcome(STAT_INVALID, ACT_NONE, 5'd0, 5'd0, ST_DEL, 1'b0)},
			'{'{MODE_DELETE, 5'd3, 1'b0, 5'd0, 5'd0}, 1'b1,
				outcome(STAT_INVALID, ACT_NONE, 5'd0, 5'd0, ST_DEL, 1'b0)},
			// The idle task may not be deleted, even as the running task.
			'{'{MODE_DELETE, 5'd2, 1'b1, 5'd31, 5'd0}, 1'b1,
				outcome(STAT_IDLE_DEL, ACT_NONE, 5'd0, 5'd0, ST_DEL, 1'b0)},
			// Create ignores the running task selection.
			'{'{MODE_CREATE, 5'd31, 1'b1, 5'd4, 5'd31}, 1'b1,
				outcome(STAT_OK, ACT_INS_RDY, 5'd31, 5'd31, ST_RDY, 1'b0)},
			'{'{MODE_CREATE, 5'd0, 1'b0, 5'd0, 5'd0}, 1'b1,
				outcome(STAT_OK, ACT_INS_RDY, 5'd0, 5'd0, ST_RDY, 1'b0)},
			'{'{MODE_RESUME, 5'd0, 1'b0, 5'd0, 5'd0}, 1'b1,
				outcome(STAT_NOT_SUSP, ACT_NONE, 5'd0, 5'd0, ST_RDY, 1'b1)},
			// Nested suspend of the running task, then two resumes.
			'{'{MODE_SUSPEND, 5'd9, 1'b1, 5'd0, 5'd0}, 1'b1,
				outcome(STAT_OK, ACT_RMV_RDY, 5'd0, 5'd0, ST_SUSP, 1'b1)},
			'{'{MODE_SUSPEND, 5'd0, 1'b0, 5'd0, 5'd0}, 1'b1,
				outcome(STAT_OK, ACT_NONE, 5'd0, 5'd0, ST_SUSP, 1'b1)},
			'{'{MODE_RESUME, 5'd0, 1'b1, 5'd31, 5'd0}, 1'b1,
				outcome(STAT_OK, ACT_NONE, 5'd0, 5'd0, ST_SUSP, 1'b1)},
			'{'{MODE_RESUME, 5'd0, 1'b0, 5'd0, 5'd0}, 1'b1,
				outcome(STAT_OK, ACT_INS_RDY, 5'd0, 5'd0, ST_RDY, 1'b1)},
			'{'{MODE_DELETE, 5'd31, 1'b0, 5'd0, 5'd0}, 1'b1,
				outcome(STAT_IDLE_DEL, ACT_NONE, 5'd0, 5'd0, ST_RDY, 1'b0)},
			// Suspending the idle task is allowed.
			'{'{MODE_SUSPEND, 5'd31, 1'b0, 5'd0, 5'd0}, 1'b1,
				outcome(STAT_OK, ACT_RMV_RDY, 5'd31, 5'd31, ST_SUSP, 1'b1)},
			'{'{MODE_DELETE, 5'd0, 1'b0, 5'd0, 5'd0}, 1'b1,
				outcome(STAT_OK, ACT_RMV_RDY, 5'd0, 5'd0, ST_DEL, 1'b1)},
			'{'{MODE_CREATE, 5'd5, 1'b0, 5'd0, 5'd17}, 1'b0, '0},
			'{'{MODE_SUSPEND, 5'd5, 1'b0, 5'd0, 5'd0}, 1'b0, '0},
			// A suspended task leaves no list behind on delete.
			'{'{MODE_DELETE, 5'd5, 1'b0, 5'd0, 5'd0}, 1'b1,
				outcome(STAT_OK, ACT_NONE, 5'd0, 5'd0, ST_DEL, 1'b1)},
			'{'{MODE_CREATE, 5'd0, 1'b0, 5'd0, 5'd21}, 1'b0, '0},
			'{'{MODE_CREATE, 5'd0, 1'b0, 5'd31, 5'd10}, 1'b0, '0},
			'{'{MODE_RESUME, 5'd31, 1'b1, 5'd0, 5'd0}, 1'b0, '0},
			'{'{MODE_SUSPEND, 5'd31, 1'b1, 5'd0, 5'd0}, 1'b0, '0},
			'{'{MODE_CREATE, 5'd0, 1'b0, 5'd0, 5'd3}, 1'b0, '0},
			'{'{MODE_RESUME, 5'd0, 1'b0, 5'd0, 5'd0}, 1'b0, '0},
			'{'{MODE_DELETE, 5'd0, 1'b0, 5'd31, 5'd31}, 1'b0, '0}
		};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_item(directed[i].req, directed[i].typed, directed[i].res);

		for (int ph = 0; ph < PHASES; ph++) begin
			wait_drained();
			if (ph == 0)
				write_idle_task('0);
			else if (ph == 1)
				write_idle_task('1);
			else
				write_idle_task(TASK_W'($urandom_range(0, 31)));
			quiet = (ph == PHASES - 1);
			if (ph == 1)
				long_hold_req = 1'b1;

			// Drive one task's suspend count into saturation and back out.
			if (ph == 2) begin
				sat_task = TASK_W'($urandom_range(0, 31));
				r.mode = MODE_CREATE;
				r.task_req = sat_task;
				r.use_current = 1'b0;
				r.current_task = TASK_W'($urandom_range(0, 31));
				r.priority_req = PRIO_W'($urandom_range(0, 31));
				send_item(r, 1'b0, '0);
				for (int k = 0; k < 260; k++) begin
					r.mode = MODE_SUSPEND;
					r.use_current = 1'($urandom_range(0, 1));
					r.task_req = r.use_current ? 5'($urandom_range(0, 31)) : sat_task;
					r.current_task = r.use_current ? sat_task : 5'($urandom_range(0, 31));
					r.priority_req = PRIO_W'($urandom_range(0, 31));
					send_item(r, 1'b0, '0);
				end
				for (int k = 0; k < 256; k++) begin
					r.mode = MODE_RESUME;
					r.task_req = sat_task;
					r.use_current = 1'($urandom_range(0, 1));
					r.current_task = TASK_W'($urandom_range(0, 31));
					r.priority_req = PRIO_W'($urandom_range(0, 31));
					send_item(r, 1'b0, '0);
				end
			end

			repeat (PHASE_ITEMS) send_item(random_request(), 1'b0, '0);
		end

		wait_drained();
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Run limit, far beyond the slowest correct run.
	initial begin
		#2000000;
		$display("Some tests failed");
		$finish;
	end

endmodule

// File: files.f
src/rtst_pkg.sv
src/rtst_ctrl.sv
src/rtst_dpath.sv
src/rtos_task_state_table_unit.sv
dv/tb_rtos_task_state_table_unit.sv
